FILE: sv/bpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_pkg
// Types and codes shared by the bounded priority queue cells and top level.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 16;
  localparam int CfgW   = 5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   ge;
    entry_t entry;
  } link_t;

  typedef struct packed {
    logic   push_en;
    logic   pop_en;
    entry_t new_entry;
  } cell_op_t;

endpackage

FILE: sv/bpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted shift chain: keeps, takes the new entry, or takes a
// neighbor's entry, driven by a broadcast push or pop.
// ----------------------------------------------------------------------------
module bpq_cell (
  input  logic             clk,
  input  logic             rst,
  input  bpq_pkg::cell_op_t op,
  input  bpq_pkg::link_t   left,
  input  bpq_pkg::link_t   right,
  output bpq_pkg::link_t   own
);
  import bpq_pkg::*;

  logic   valid;
  entry_t entry;
  logic   ge;

  assign ge  = valid && (entry.prio >= op.new_entry.prio);
  assign own = '{valid: valid, ge: ge, entry: entry};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.push_en) begin
      valid <= valid | left.valid;
    end else if (op.pop_en) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push_en) begin
      if (!ge) begin
        entry <= left.ge ? op.new_entry : left.entry;
      end
    end else if (op.pop_en) begin
      entry <= right.entry;
    end
  end

endmodule

FILE: sv/bounded_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_priority_queue_unit
// Bounded priority queue built as a sorted chain of cells, highest priority
// at the head, ties kept in arrival order.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata: in_value[31:0], in_priority[47:32]; tuser: func
// m_axis    out  tdata: out_value, out_priority, now_full, now_empty; tuser: status
// cfg       in   cfg_we / cfg_wdata: capacity_in_use
//
// One transfer per cycle while the output is not stalled: every cell shifts or holds
// in the cycle a push or pop is taken, and the result is registered at that same edge.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// rst is synchronous: queue empty, capacity_in_use = 16, no result pending.
// ----------------------------------------------------------------------------
module bounded_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // in_value[31:0], in_priority[47:32]
  input  logic [0:0]  s_axis_tuser,   // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_value[31:0], out_priority[47:32],
                                      // now_full[48], now_empty[49], zero[55:50]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic [bpq_pkg::CfgW-1:0] cfg_wdata
);
  import bpq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CfgW-1:0] capacity_in_use;
  logic [CntW-1:0] count, count_next, cap_eff;
  logic            accept, is_pop, push_ok, pop_ok;
  logic [1:0]      status_next;
  cell_op_t        op;
  link_t           link [CAPACITY];

  logic              out_valid;
  logic [1:0]        out_status;
  entry_t            out_entry;
  logic              out_full, out_empty;

  always_comb begin
    if (capacity_in_use == '0) begin
      cap_eff = CntW'(1);
    end else if (32'(capacity_in_use) > CAPACITY) begin
      cap_eff = CntW'(CAPACITY);
    end else begin
      cap_eff = CntW'(capacity_in_use);
    end
  end

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_pop        = (s_axis_tuser[0] == FUNC_POP);
  assign push_ok       = accept && !is_pop && (count < cap_eff);
  assign pop_ok        = accept && is_pop && (count != '0);

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CntW'(1);
    end else if (pop_ok) begin
      count_next = count - CntW'(1);
    end
    if (is_pop) begin
      status_next = pop_ok ? ST_POPPED : ST_EMPTY;
    end else begin
      status_next = push_ok ? ST_PUSHED : ST_FULL;
    end
  end

  assign op.push_en         = push_ok;
  assign op.pop_en          = pop_ok;
  assign op.new_entry.value = s_axis_tdata[31:0];
  assign op.new_entry.prio  = s_axis_tdata[47:32];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = '{valid: 1'b1, ge: 1'b1, entry: op.new_entry};
    end else begin : g_mid
      assign left_l = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = '{valid: 1'b0, ge: 1'b0, entry: '0};
    end else begin : g_inner
      assign right_l = link[i+1];
    end
    bpq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .op   (op),
      .left (left_l),
      .right(right_l),
      .own  (link[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CfgW'(16);
      count           <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_in_use <= cfg_wdata;
      end
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_entry  <= pop_ok ? link[0].entry : '0;
      out_full   <= (count_next >= cap_eff);
      out_empty  <= (count_next == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {6'b0, out_empty, out_full, out_entry.prio, out_entry.value};

endmodule

FILE: verif/tb_bounded_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_priority_queue_unit
// Self-checking bench for the bounded priority queue: a directed run over
// empty pops, full rejections, value and priority extremes, ties and capacity
// changes, then random push/pop phases at many capacity settings. A scoreboard
// predicts every result from an in-bench sorted queue and checks it field by
// field against the output stream, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_bounded_priority_queue_unit;
  import bpq_pkg::*;

  localparam int Depth = 16;

  typedef struct packed {
    logic                     func;
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
  } op_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
    logic                     full;
    logic                     empty;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata = '0;
  logic [0:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [55:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_we = 1'b0;
  logic [CfgW-1:0]   cfg_wdata = '0;

  op_t         pending_ops[$];
  outcome_t    outcomes_due[$];
  op_t         on_wire;
  outcome_t    want;
  outcome_t    seen;

  entry_t      sorted_store[Depth];
  int unsigned occupancy = 0;
  logic [4:0]  cap_reg = 5'd16;
  bit          calm = 1'b0;

  int unsigned mismatches = 0;
  int unsigned n_checked = 0;
  int unsigned n_pushed = 0;
  int unsigned n_popped = 0;
  int unsigned n_rejected = 0;
  int unsigned n_empty_pops = 0;
  int unsigned deepest = 0;

  bounded_priority_queue_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // in_value[31:0], in_priority[47:32]
    .s_axis_tuser  (s_axis_tuser),   // func[0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_value[31:0], out_priority[47:32],
                                     // now_full[48], now_empty[49]
    .m_axis_tuser  (m_axis_tuser),   // status[1:0]
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic outcome_t queue_apply(input op_t op);
    outcome_t    r;
    int unsigned cap;
    int unsigned pos;
    r = '0;
    cap = cap_reg;
    if (cap < 1) cap = 1;
    if (cap > Depth) cap = Depth;
    if (op.func == FUNC_PUSH) begin
      if (occupancy >= cap) begin
        r.status = ST_FULL;
      end else begin
        pos = occupancy;
        while (pos > 0 && sorted_store[pos-1].prio < op.prio) begin
          sorted_store[pos] = sorted_store[pos-1];
          pos--;
        end
        sorted_store[pos].value = op.value;
        sorted_store[pos].prio  = op.prio;
        occupancy++;
        r.status = ST_PUSHED;
      end
    end else begin
      if (occupancy == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value = sorted_store[0].value;
        r.prio  = sorted_store[0].prio;
        for (int k = 1; k < occupancy; k++) sorted_store[k-1] = sorted_store[k];
        occupancy--;
        r.status = ST_POPPED;
      end
    end
    r.full  = (occupancy >= cap);
    r.empty = (occupancy == 0);
    if (occupancy > deepest) deepest = occupancy;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint exp_v,
                                 input longint got_v);
    $display("MISMATCH t=%0t result %0d: %s expected 0x%0h got 0x%0h",
             $time, n_checked, field, exp_v, got_v);
    mismatches++;
  endtask

  task automatic add_op(input logic func, input logic [31:0] value,
                        input logic [15:0] prio);
    op_t op;
    op.func  = func;
    op.value = value;
    op.prio  = prio;
    pending_ops.push_back(op);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_ops.size() != 0 || s_axis_tvalid || outcomes_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cap_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_prio();
    case ($urandom_range(9))
      0:             return 16'h0000;
      1:             return 16'hFFFF;
      2, 3, 4, 5, 6: return 16'($urandom_range(3));
      default:       return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcomes_due.push_back(queue_apply(on_wire));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          on_wire = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {on_wire.prio, on_wire.value};
          s_axis_tuser  <= on_wire.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.status = m_axis_tuser;
        seen.value  = m_axis_tdata[31:0];
        seen.prio   = m_axis_tdata[47:32];
        seen.full   = m_axis_tdata[48];
        seen.empty  = m_axis_tdata[49];
        if (outcomes_due.size() == 0) begin
          report_mismatch("unexpected result, status", 0, seen.status);
        end else begin
          want = outcomes_due.pop_front();
          if (seen.status !== want.status)
            report_mismatch("status", want.status, seen.status);
          if (seen.value !== want.value)
            report_mismatch("out_value", want.value, seen.value);
          if (seen.prio !== want.prio)
            report_mismatch("out_priority", want.prio, seen.prio);
          if (seen.full !== want.full)
            report_mismatch("now_full", want.full, seen.full);
          if (seen.empty !== want.empty)
            report_mismatch("now_empty", want.empty, seen.empty);
          case (want.status)
            ST_PUSHED: n_pushed++;
            ST_POPPED: n_popped++;
            ST_FULL:   n_rejected++;
            default:   n_empty_pops++;
          endcase
        end
        n_checked++;
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    logic [4:0] phase_caps[12];
    int         push_pct;
    int         drain_limit;

    phase_caps = '{5'd31, 5'd16, 5'd2, 5'd0, 5'd1, 5'd7,
                   5'd16, 5'd5, 5'd31, 5'd20, 5'd3, 5'd16};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: empty pop, extremes, ties, drain to empty
    add_op(FUNC_POP,  32'hFFFF_FFFF, 16'hFFFF);
    add_op(FUNC_PUSH, 32'h7FFF_FFFF, 16'h0000);
    add_op(FUNC_PUSH, 32'h8000_0000, 16'hFFFF);
    add_op(FUNC_PUSH, 32'h0000_0000, 16'h0005);
    add_op(FUNC_PUSH, 32'hFFFF_FFFF, 16'h0005);
    add_op(FUNC_PUSH, 32'h0000_0002, 16'h0000);
    repeat (5) add_op(FUNC_POP, 32'h0, 16'h0);
    add_op(FUNC_POP, 32'h0, 16'h0);

    // smallest capacity, then zero which acts as one
    write_capacity(5'd1);
    add_op(FUNC_PUSH, 32'd10, 16'd3);
    add_op(FUNC_PUSH, 32'd11, 16'd9);
    add_op(FUNC_POP,  32'd0,  16'd0);
    write_capacity(5'd0);
    add_op(FUNC_PUSH, 32'd12, 16'd1);
    add_op(FUNC_PUSH, 32'd13, 16'd1);
    add_op(FUNC_POP,  32'd0,  16'd0);

    // lower capacity below the stored count
    write_capacity(5'd16);
    add_op(FUNC_PUSH, 32'd20, 16'd4);
    add_op(FUNC_PUSH, 32'd21, 16'd8);
    add_op(FUNC_PUSH, 32'd22, 16'd4);
    write_capacity(5'd2);
    add_op(FUNC_PUSH, 32'd23, 16'd9);
    repeat (4) add_op(FUNC_POP, 32'd0, 16'd0);

    for (int ph = 0; ph < 12; ph++) begin
      write_capacity(ph == 5 || ph == 9 ? 5'($urandom_range(31)) : phase_caps[ph]);
      calm = (ph == 4);
      case (ph % 3)
        0:       push_pct = 75;
        1:       push_pct = 50;
        default: push_pct = 30;
      endcase
      for (int i = 0; i < 145; i++) begin
        if ($urandom_range(99) < push_pct)
          add_op(FUNC_PUSH, pick_value(), pick_prio());
        else
          add_op(FUNC_POP, $urandom, 16'($urandom_range(16'hFFFF)));
      end
    end

    @(negedge clk);
    while (pending_ops.size() != 0 || s_axis_tvalid) @(negedge clk);
    drain_limit = 10000;
    while (outcomes_due.size() != 0 && drain_limit > 0) begin
      @(negedge clk);
      drain_limit--;
    end
    repeat (10) @(negedge clk);
    if (outcomes_due.size() != 0)
      report_mismatch("results never delivered", outcomes_due.size(), 0);

    $display("Checked %0d results: %0d pushes, %0d pops, %0d full rejects, %0d empty pops",
             n_checked, n_pushed, n_popped, n_rejected, n_empty_pops);
    $display("Capacities 0, 1, 2, 16, 31 and random values; deepest occupancy %0d",
             deepest);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout after %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: bounded_priority_queue_unit.f
sv/bpq_pkg.sv
sv/bpq_cell.sv
sv/bounded_priority_queue_unit.sv
verif/tb_bounded_priority_queue_unit.sv
